// ----- hw/rtl/lsled_pkg.sv -----
package lsled_pkg;

    localparam int TIME_BITS = 32;
    localparam logic [31:0] TIME_MASK = (TIME_BITS >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << TIME_BITS) - 64'd1);

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    localparam logic [2:0] ST_PROV        = 3'd0;
    localparam logic [2:0] ST_CONN_LINK   = 3'd1;
    localparam logic [2:0] ST_CONN_BROKER = 3'd2;
    localparam logic [2:0] ST_RUNNING     = 3'd3;
    localparam logic [2:0] ST_ERR_LINK    = 3'd4;
    localparam logic [2:0] ST_ERR_BROKER  = 3'd5;
    localparam logic [2:0] ST_ERR_SENSOR  = 3'd6;
    localparam logic [2:0] ST_FACTORY     = 3'd7;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_FORCE = 2'd2;

    localparam logic [1:0] LINK_CONNECTED   = 2'd1;
    localparam logic [1:0] LINK_ERROR       = 2'd2;
    localparam logic [1:0] BRK_DISCONNECTED = 2'd0;
    localparam logic [1:0] BRK_CONNECTED    = 2'd1;
    localparam logic [1:0] BRK_ERROR        = 2'd2;
    localparam logic [1:0] MODE_BROKER      = 2'd1;
    localparam logic [3:0] FAIL_MAX         = 4'd15;

    localparam logic REG_UPLOAD_MODE = 1'b0;
    localparam logic REG_FAIL_LIMIT  = 1'b1;

    localparam logic [1:0] UPLOAD_MODE_RESET = 2'd0;
    localparam logic [3:0] FAIL_LIMIT_RESET  = 4'd10;

    // blink periods and their fold / reciprocal constants
    localparam int NUM_PERIODS  = 4;
    localparam int P_PROV       = 0;
    localparam int P_LINK       = 1;
    localparam int P_ERR_LINK   = 2;
    localparam int P_ERR_SENSOR = 3;

    localparam int PERIOD [NUM_PERIODS] = '{2200, 600, 1600, 3500};
    localparam int FOLD1  [NUM_PERIODS] = '{256 % 2200, 256 % 600, 256 % 1600, 256 % 3500};
    localparam int FOLD2  [NUM_PERIODS] = '{65536 % 2200, 65536 % 600,
                                            65536 % 1600, 65536 % 3500};
    localparam int FOLD3  [NUM_PERIODS] = '{16777216 % 2200, 16777216 % 600,
                                            16777216 % 1600, 16777216 % 3500};
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP  [NUM_PERIODS] = '{16777216 / 2200, 16777216 / 600,
                                            16777216 / 1600, 16777216 / 3500};

    typedef logic [21:0] fold_t;
    typedef logic [12:0] quot_t;
    typedef logic [11:0] resid_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] link_status;
        logic [1:0] broker_status;
        logic       sensor_ready;
        logic       credentials_stored;
        logic [2:0] target_state;
    } item_ctrl_t;

    typedef struct packed {
        logic [2:0] current_state;
        logic [3:0] sensor_fail_count;
        logic       broker_started;
    } sup_state_t;

    typedef struct packed {
        logic [1:0] upload_mode;
        logic [3:0] fail_limit;
    } sup_cfg_t;

    typedef struct packed {
        logic led_lit;
        logic broker_reset_cmd;
        logic broker_connect_cmd;
    } step_flags_t;

endpackage

// ----- hw/rtl/lsled_step.sv -----
module lsled_step (
    input  lsled_pkg::sup_state_t  cur_state,
    input  lsled_pkg::item_ctrl_t  item,
    input  lsled_pkg::sup_cfg_t    cfg,
    input  logic [lsled_pkg::NUM_PERIODS-1:0] lit,
    output lsled_pkg::sup_state_t  nxt_state,
    output lsled_pkg::step_flags_t flags
);

    logic [2:0] st;
    logic [3:0] cnt_inc;

    always_comb begin
        nxt_state = cur_state;
        st        = cur_state.current_state;
        flags     = '0;
        cnt_inc   = (cur_state.sensor_fail_count < lsled_pkg::FAIL_MAX)
                  ? cur_state.sensor_fail_count + 4'd1 : cur_state.sensor_fail_count;
        case (item.opcode)
            lsled_pkg::OP_BEGIN: begin
                st = item.credentials_stored ? lsled_pkg::ST_CONN_LINK : lsled_pkg::ST_PROV;
            end
            lsled_pkg::OP_FORCE: begin
                st = item.target_state;
            end
            lsled_pkg::OP_TICK: begin
                case (cur_state.current_state)
                    lsled_pkg::ST_PROV: begin
                        if (item.credentials_stored) begin
                            st = lsled_pkg::ST_CONN_LINK;
                        end
                    end
                    lsled_pkg::ST_CONN_LINK, lsled_pkg::ST_ERR_LINK: begin
                        if (item.link_status == lsled_pkg::LINK_CONNECTED) begin
                            if (cfg.upload_mode == lsled_pkg::MODE_BROKER) begin
                                flags.broker_reset_cmd   = 1'b1;
                                flags.broker_connect_cmd = 1'b1;
                                nxt_state.broker_started = 1'b1;
                                st = lsled_pkg::ST_CONN_BROKER;
                            end else begin
                                nxt_state.broker_started = 1'b0;
                                st = lsled_pkg::ST_RUNNING;
                            end
                        end else if (cur_state.current_state == lsled_pkg::ST_CONN_LINK &&
                                     item.link_status == lsled_pkg::LINK_ERROR) begin
                            st = lsled_pkg::ST_ERR_LINK;
                        end
                    end
                    lsled_pkg::ST_CONN_BROKER: begin
                        if (!cur_state.broker_started) begin
                            flags.broker_connect_cmd = 1'b1;
                            nxt_state.broker_started = 1'b1;
                        end
                        if (item.broker_status == lsled_pkg::BRK_CONNECTED) begin
                            st = lsled_pkg::ST_RUNNING;
                        end else if (item.broker_status == lsled_pkg::BRK_ERROR) begin
                            st = lsled_pkg::ST_ERR_BROKER;
                        end
                    end
                    lsled_pkg::ST_RUNNING: begin
                        if (item.link_status != lsled_pkg::LINK_CONNECTED) begin
                            nxt_state.broker_started = 1'b0;
                            st = lsled_pkg::ST_ERR_LINK;
                        end else if (!item.sensor_ready) begin
                            nxt_state.sensor_fail_count = cnt_inc;
                            if (cnt_inc > cfg.fail_limit) begin
                                st = lsled_pkg::ST_ERR_SENSOR;
                            end
                        end else begin
                            nxt_state.sensor_fail_count = 4'd0;
                        end
                    end
                    lsled_pkg::ST_ERR_BROKER: begin
                        if (item.link_status != lsled_pkg::LINK_CONNECTED) begin
                            nxt_state.broker_started = 1'b0;
                            st = lsled_pkg::ST_ERR_LINK;
                        end else if (item.broker_status == lsled_pkg::BRK_CONNECTED) begin
                            st = lsled_pkg::ST_RUNNING;
                        end else if (item.broker_status == lsled_pkg::BRK_DISCONNECTED) begin
                            flags.broker_connect_cmd = 1'b1;
                            nxt_state.broker_started = 1'b1;
                            st = lsled_pkg::ST_CONN_BROKER;
                        end
                    end
                    lsled_pkg::ST_ERR_SENSOR: begin
                        if (item.sensor_ready) begin
                            nxt_state.sensor_fail_count = 4'd0;
                            st = lsled_pkg::ST_RUNNING;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        nxt_state.current_state = st;

        // blink pattern of the resulting state
        case (st)
            lsled_pkg::ST_PROV:        flags.led_lit = lit[lsled_pkg::P_PROV];
            lsled_pkg::ST_CONN_LINK,
            lsled_pkg::ST_CONN_BROKER: flags.led_lit = lit[lsled_pkg::P_LINK];
            lsled_pkg::ST_RUNNING:     flags.led_lit = 1'b1;
            lsled_pkg::ST_ERR_LINK:    flags.led_lit = lit[lsled_pkg::P_ERR_LINK];
            lsled_pkg::ST_ERR_SENSOR:  flags.led_lit = lit[lsled_pkg::P_ERR_SENSOR];
            default:                   flags.led_lit = 1'b0;
        endcase
    end

endmodule

// ----- hw/rtl/link_supervisor_with_led_patterns.sv -----
// Link supervisor with LED patterns. Takes one transfer per cycle at a sustained
// rate while the output is not stalled and returns one result transfer per input,
// in order, after it passes the stage registers and the output register. Three
// pipeline stages reduce the millisecond time modulo the four blink periods (byte
// fold, reciprocal multiply, multiply-back and correction). The supervisor state,
// fail count and LED register are updated as an item enters the output register,
// so consecutive items chain through the state without waiting. Internal stages
// close up bubbles, so input transfers keep being taken while a result waits,
// until every stage holds an item. The LED output is active low and only ticks
// refresh it. Registers sit at byte 0x0 (upload_mode) and 0x4 (fail_limit); the
// user must write them only while the block is idle; the block does not enforce it.
module link_supervisor_with_led_patterns (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms[31:0] link_status[33:32] broker_status[35:34] sensor_ready[36]
    // credentials_stored[37] target_state[40:38] zero[47:41]
    input  logic [lsled_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // state_code[2:0] state_changed[3] led_level[4] broker_reset_cmd[5]
    // broker_connect_cmd[6] zero[7]
    output logic [lsled_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NP = lsled_pkg::NUM_PERIODS;

    lsled_pkg::sup_cfg_t   cfg_reg;
    lsled_pkg::sup_state_t state_reg;
    lsled_pkg::sup_state_t state_next;
    lsled_pkg::step_flags_t step_flags;
    logic                  led_reg;
    logic                  led_next;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic                  rdy1, rdy2, rdy3, rdy4, adv_out;
    lsled_pkg::item_ctrl_t item_in, item1_reg, item2_reg, item3_reg, item4_reg;
    logic [31:0]           t1_reg;
    lsled_pkg::fold_t      y2_reg [NP];
    lsled_pkg::fold_t      y3_reg [NP];
    lsled_pkg::quot_t      q3_reg [NP];
    logic [NP-1:0]         lit4_reg;
    logic [lsled_pkg::M_TDATA_W-1:0] out_data_reg;

    lsled_pkg::fold_t      y_next [NP];
    lsled_pkg::quot_t      q_next [NP];
    logic [37:0]           qprod  [NP];
    lsled_pkg::fold_t      diff   [NP];
    logic [12:0]           diff13 [NP];
    lsled_pkg::resid_t     resid  [NP];
    logic [NP-1:0]         lit_next;
    logic                  wr_en;

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            lsled_pkg::REG_UPLOAD_MODE: prdata = {30'd0, cfg_reg.upload_mode};
            lsled_pkg::REG_FAIL_LIMIT:  prdata = {28'd0, cfg_reg.fail_limit};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.upload_mode <= lsled_pkg::UPLOAD_MODE_RESET;
            cfg_reg.fail_limit  <= lsled_pkg::FAIL_LIMIT_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                lsled_pkg::REG_UPLOAD_MODE: cfg_reg.upload_mode <= pwdata[1:0];
                lsled_pkg::REG_FAIL_LIMIT:  cfg_reg.fail_limit  <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // stage handshake
    assign adv_out  = !out_valid_reg || m_tready;
    assign rdy4     = !v4_reg || adv_out;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign item_in.opcode             = s_tuser;
    assign item_in.link_status        = s_tdata[33:32];
    assign item_in.broker_status      = s_tdata[35:34];
    assign item_in.sensor_ready       = s_tdata[36];
    assign item_in.credentials_stored = s_tdata[37];
    assign item_in.target_state       = s_tdata[40:38];

    // residues of the time modulo each blink period, and the lit phase of each pattern
    always_comb begin
        for (int i = 0; i < NP; i++) begin
            y_next[i] = lsled_pkg::fold_t'(t1_reg[7:0])
                      + lsled_pkg::fold_t'(t1_reg[15:8])  * lsled_pkg::fold_t'(lsled_pkg::FOLD1[i])
                      + lsled_pkg::fold_t'(t1_reg[23:16]) * lsled_pkg::fold_t'(lsled_pkg::FOLD2[i])
                      + lsled_pkg::fold_t'(t1_reg[31:24]) * lsled_pkg::fold_t'(lsled_pkg::FOLD3[i]);
            qprod[i]  = 38'(y2_reg[i]) * 38'(lsled_pkg::RECIP[i]);
            q_next[i] = qprod[i][lsled_pkg::RECIP_SHIFT +: 13];
            diff[i]   = y3_reg[i]
                      - lsled_pkg::fold_t'(q3_reg[i]) * lsled_pkg::fold_t'(lsled_pkg::PERIOD[i]);
            diff13[i] = diff[i][12:0];
            resid[i]  = (diff13[i] >= 13'(lsled_pkg::PERIOD[i]))
                      ? 12'(diff13[i] - 13'(lsled_pkg::PERIOD[i])) : diff13[i][11:0];
        end
        lit_next[lsled_pkg::P_PROV] = resid[lsled_pkg::P_PROV] < 12'd200;
        lit_next[lsled_pkg::P_LINK] = resid[lsled_pkg::P_LINK] < 12'd100;
        lit_next[lsled_pkg::P_ERR_LINK] =
            (resid[lsled_pkg::P_ERR_LINK] < 12'd200)
         || (resid[lsled_pkg::P_ERR_LINK] >= 12'd400 && resid[lsled_pkg::P_ERR_LINK] < 12'd600)
         || (resid[lsled_pkg::P_ERR_LINK] >= 12'd800 && resid[lsled_pkg::P_ERR_LINK] < 12'd1000);
        lit_next[lsled_pkg::P_ERR_SENSOR] =
            (resid[lsled_pkg::P_ERR_SENSOR] < 12'd500)
         || (resid[lsled_pkg::P_ERR_SENSOR] >= 12'd1000
             && resid[lsled_pkg::P_ERR_SENSOR] < 12'd1500)
         || (resid[lsled_pkg::P_ERR_SENSOR] >= 12'd2000
             && resid[lsled_pkg::P_ERR_SENSOR] < 12'd2500);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy1)    v1_reg        <= s_tvalid;
            if (rdy2)    v2_reg        <= v1_reg;
            if (rdy3)    v3_reg        <= v2_reg;
            if (rdy4)    v4_reg        <= v3_reg;
            if (adv_out) out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            item1_reg <= item_in;
            t1_reg    <= s_tdata[31:0] & lsled_pkg::TIME_MASK;
        end
        if (rdy2) begin
            item2_reg <= item1_reg;
            y2_reg    <= y_next;
        end
        if (rdy3) begin
            item3_reg <= item2_reg;
            y3_reg    <= y2_reg;
            q3_reg    <= q_next;
        end
        if (rdy4) begin
            item4_reg <= item3_reg;
            lit4_reg  <= lit_next;
        end
    end

    lsled_step u_step (
        .cur_state (state_reg),
        .item      (item4_reg),
        .cfg       (cfg_reg),
        .lit       (lit4_reg),
        .nxt_state (state_next),
        .flags     (step_flags)
    );

    assign led_next = (item4_reg.opcode == lsled_pkg::OP_TICK) ? !step_flags.led_lit : led_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{current_state: lsled_pkg::ST_PROV,
                           sensor_fail_count: 4'd0, broker_started: 1'b0};
            led_reg   <= 1'b1;
        end else if (v4_reg && adv_out) begin
            state_reg <= state_next;
            led_reg   <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (v4_reg && adv_out) begin
            out_data_reg <= {1'b0,
                             step_flags.broker_connect_cmd,
                             step_flags.broker_reset_cmd,
                             led_next,
                             state_next.current_state != state_reg.current_state,
                             state_next.current_state};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_reset_pulse_in_conn_broker: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[5] |-> out_data_reg[2:0] == lsled_pkg::ST_CONN_BROKER)
        else $error("broker reset pulse outside connecting-broker state");

    a_accept_fills_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted transfer lost at first stage");

    a_state_moves_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(v4_reg && adv_out) |=> $stable(state_reg))
        else $error("supervisor state changed without a result");
`endif

endmodule

// ----- sim/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsled_pkg::*;

    localparam int PER_PROV       = 2200;
    localparam int PER_LINK       = 600;
    localparam int PER_ERR_LINK   = 1600;
    localparam int PER_ERR_SENSOR = 3500;
    localparam int LATENCY        = 5;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam logic [1:0] LINK_OTHER = 2'd0;
    localparam logic [1:0] LINK_UNDEF = 2'd3;
    localparam logic [1:0] BRK_OTHER  = 2'd3;

    typedef struct {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic [1:0]  link;
        logic [1:0]  brk;
        logic        ready;
        logic        creds;
        logic [2:0]  target;
    } sup_item_t;

    typedef struct packed {
        logic       con_cmd;
        logic       rst_cmd;
        logic       led_level;
        logic       state_changed;
        logic [2:0] state_code;
    } sup_report_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [31:0] prdata;
    logic        pready;

    logic [2:0]  sup_state     = ST_PROV;
    logic [3:0]  not_ready_run = 4'd0;
    logic        broker_up     = 1'b0;
    logic        led_pin       = 1'b1;
    logic [1:0]  upload_mode   = UPLOAD_MODE_RESET;
    logic [3:0]  fail_limit    = FAIL_LIMIT_RESET;

    sup_report_t expected_reports[$];
    int          errors        = 0;
    int          src_idle_pct  = 9;
    int          sink_idle_pct = 61;
    logic [31:0] clock_ms      = '0;
    logic        sensor_down   = 1'b0;
    logic        link_bad      = 1'b0;

    link_supervisor_with_led_patterns u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic blink_lit(logic [2:0] st, logic [31:0] now);
        longint unsigned t;
        longint unsigned c;
        t = now & TIME_MASK;
        case (st)
            ST_PROV: return (t % PER_PROV) < 200;
            ST_CONN_LINK, ST_CONN_BROKER: return (t % PER_LINK) < 100;
            ST_RUNNING: return 1'b1;
            ST_ERR_LINK: begin
                c = t % PER_ERR_LINK;
                return c < 200 || (c >= 400 && c < 600) || (c >= 800 && c < 1000);
            end
            ST_ERR_SENSOR: begin
                c = t % PER_ERR_SENSOR;
                return c < 500 || (c >= 1000 && c < 1500) || (c >= 2000 && c < 2500);
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic sup_report_t advance_supervisor(sup_item_t it);
        sup_report_t rep;
        logic [2:0]  nxt;
        rep = '0;
        nxt = sup_state;
        case (it.opcode)
            OP_BEGIN: nxt = it.creds ? ST_CONN_LINK : ST_PROV;
            OP_FORCE: nxt = it.target;
            OP_TICK: begin
                case (sup_state)
                    ST_PROV: if (it.creds) nxt = ST_CONN_LINK;
                    ST_CONN_LINK, ST_ERR_LINK: begin
                        if (it.link == LINK_CONNECTED) begin
                            broker_up = 1'b0;
                            if (upload_mode == MODE_BROKER) begin
                                rep.rst_cmd = 1'b1;
                                rep.con_cmd = 1'b1;
                                broker_up   = 1'b1;
                                nxt         = ST_CONN_BROKER;
                            end else begin
                                nxt = ST_RUNNING;
                            end
                        end else if (sup_state == ST_CONN_LINK && it.link == LINK_ERROR) begin
                            nxt = ST_ERR_LINK;
                        end
                    end
                    ST_CONN_BROKER: begin
                        if (!broker_up) begin
                            rep.con_cmd = 1'b1;
                            broker_up   = 1'b1;
                        end
                        if (it.brk == BRK_CONNECTED)
                            nxt = ST_RUNNING;
                        else if (it.brk == BRK_ERROR)
                            nxt = ST_ERR_BROKER;
                    end
                    ST_RUNNING: begin
                        if (it.link != LINK_CONNECTED) begin
                            broker_up = 1'b0;
                            nxt       = ST_ERR_LINK;
                        end else if (!it.ready) begin
                            if (not_ready_run < FAIL_MAX)
                                not_ready_run++;
                            if (not_ready_run > fail_limit)
                                nxt = ST_ERR_SENSOR;
                        end else begin
                            not_ready_run = 4'd0;
                        end
                    end
                    ST_ERR_BROKER: begin
                        if (it.link != LINK_CONNECTED) begin
                            broker_up = 1'b0;
                            nxt       = ST_ERR_LINK;
                        end else if (it.brk == BRK_CONNECTED) begin
                            nxt = ST_RUNNING;
                        end else if (it.brk == BRK_DISCONNECTED) begin
                            rep.con_cmd = 1'b1;
                            broker_up   = 1'b1;
                            nxt         = ST_CONN_BROKER;
                        end
                    end
                    ST_ERR_SENSOR: begin
                        if (it.ready) begin
                            not_ready_run = 4'd0;
                            nxt           = ST_RUNNING;
                        end
                    end
                    default: ;
                endcase
                led_pin = !blink_lit(nxt, it.now_ms);
            end
            default: ;
        endcase
        rep.state_changed = (nxt != sup_state);
        rep.state_code    = nxt;
        rep.led_level     = led_pin;
        sup_state         = nxt;
        return rep;
    endfunction

    function automatic sup_item_t make_item(logic [1:0] op, logic [31:0] now, logic [1:0] link,
                                            logic [1:0] brk, logic ready, logic creds,
                                            logic [2:0] target);
        sup_item_t it;
        it.opcode = op;
        it.now_ms = now;
        it.link   = link;
        it.brk    = brk;
        it.ready  = ready;
        it.creds  = creds;
        it.target = target;
        return it;
    endfunction

    function automatic sup_item_t random_item();
        sup_item_t it;
        int        r;
        r = $urandom_range(99);
        it.opcode = (r < 82) ? OP_TICK : (r < 90) ? OP_BEGIN : (r < 97) ? OP_FORCE : OP_IGNORED;
        clock_ms = clock_ms + $urandom_range(900);
        it.now_ms = ($urandom_range(99) < 5) ? $urandom : clock_ms;
        if (link_bad)
            link_bad = ($urandom_range(99) >= 30);
        else
            link_bad = ($urandom_range(99) < 4);
        it.link = link_bad ? 2'($urandom_range(3)) : LINK_CONNECTED;
        it.brk  = 2'($urandom_range(3));
        if (sensor_down)
            sensor_down = ($urandom_range(99) >= 8);
        else
            sensor_down = ($urandom_range(99) < 4);
        it.ready  = !sensor_down;
        it.creds  = ($urandom_range(99) < 85);
        it.target = 3'($urandom_range(7));
        return it;
    endfunction

    task automatic send_item(sup_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.opcode;
        s_tdata  <= {7'b0, it.target, it.creds, it.ready, it.brk, it.link, it.now_ms};
        do @(posedge aclk); while (!s_tready);
        expected_reports.push_back(advance_supervisor(it));
    endtask

    task automatic drain_reports();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_UPLOAD_MODE)
            upload_mode = value[1:0];
        else
            fail_limit = value[3:0];
    endtask

    task automatic configure(logic [1:0] mode, logic [3:0] limit);
        drain_reports();
        write_reg(REG_UPLOAD_MODE, 32'(mode));
        write_reg(REG_FAIL_LIMIT, 32'(limit));
    endtask

    task automatic test_directed();
        send_item(make_item(OP_TICK, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b0, ST_PROV));
        send_item(make_item(OP_IGNORED, 32'hFFFF_FFFF, LINK_UNDEF, BRK_OTHER, 1'b1, 1'b1,
                            ST_FACTORY));
        send_item(make_item(OP_TICK, 32'd200, LINK_OTHER, BRK_DISCONNECTED, 1'b1, 1'b0, ST_PROV));
        send_item(make_item(OP_BEGIN, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b0, ST_PROV));
        send_item(make_item(OP_BEGIN, 32'd5, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b1, ST_PROV));
        send_item(make_item(OP_TICK, 32'hFFFF_FFFF, LINK_UNDEF, BRK_OTHER, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_TICK, 32'd450, LINK_ERROR, BRK_DISCONNECTED, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_TICK, 32'd950, LINK_ERROR, BRK_DISCONNECTED, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_TICK, 32'd1000, LINK_CONNECTED, BRK_CONNECTED, 1'b1, 1'b1,
                            ST_PROV));
        send_item(make_item(OP_TICK, 32'd1001, LINK_CONNECTED, BRK_CONNECTED, 1'b0, 1'b1,
                            ST_PROV));
        send_item(make_item(OP_TICK, 32'd1002, LINK_CONNECTED, BRK_CONNECTED, 1'b1, 1'b1,
                            ST_PROV));
        send_item(make_item(OP_TICK, 32'd1003, LINK_OTHER, BRK_CONNECTED, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_FORCE, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b0,
                            ST_FACTORY));
        send_item(make_item(OP_TICK, 32'd10, LINK_CONNECTED, BRK_CONNECTED, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_FORCE, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b0,
                            ST_ERR_BROKER));
        send_item(make_item(OP_TICK, 32'd20, LINK_CONNECTED, BRK_OTHER, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_TICK, 32'd650, LINK_CONNECTED, BRK_DISCONNECTED, 1'b1, 1'b1,
                            ST_PROV));
        send_item(make_item(OP_TICK, 32'd700, LINK_CONNECTED, BRK_ERROR, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_TICK, 32'd710, LINK_CONNECTED, BRK_CONNECTED, 1'b1, 1'b1,
                            ST_PROV));
        send_item(make_item(OP_FORCE, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b0,
                            ST_ERR_SENSOR));
        send_item(make_item(OP_TICK, 32'd1200, LINK_CONNECTED, BRK_CONNECTED, 1'b0, 1'b1,
                            ST_PROV));
        send_item(make_item(OP_TICK, 32'd1700, LINK_CONNECTED, BRK_CONNECTED, 1'b1, 1'b1,
                            ST_PROV));
        send_item(make_item(OP_FORCE, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b0,
                            ST_CONN_BROKER));
        send_item(make_item(OP_TICK, 32'd60, LINK_CONNECTED, BRK_DISCONNECTED, 1'b1, 1'b1,
                            ST_PROV));
        send_item(make_item(OP_FORCE, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b0,
                            ST_ERR_LINK));
        send_item(make_item(OP_FORCE, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b0,
                            ST_RUNNING));
        send_item(make_item(OP_FORCE, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b0,
                            ST_CONN_LINK));
        send_item(make_item(OP_FORCE, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b0,
                            ST_PROV));
    endtask

    // not-ready count saturates and never trips the top limit, but trips a limit of 14
    task automatic test_fail_count_limits();
        configure(2'd0, 4'd15);
        send_item(make_item(OP_BEGIN, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_TICK, 32'd0, LINK_CONNECTED, BRK_CONNECTED, 1'b1, 1'b1, ST_PROV));
        repeat (20)
            send_item(make_item(OP_TICK, $urandom, LINK_CONNECTED, BRK_CONNECTED, 1'b0, 1'b1,
                                ST_PROV));
        configure(2'd2, 4'd14);
        send_item(make_item(OP_TICK, 32'd3400, LINK_CONNECTED, BRK_CONNECTED, 1'b0, 1'b1,
                            ST_PROV));
        send_item(make_item(OP_TICK, 32'd3600, LINK_CONNECTED, BRK_CONNECTED, 1'b1, 1'b1,
                            ST_PROV));
    endtask

    task automatic test_broker_session();
        configure(MODE_BROKER, 4'd0);
        send_item(make_item(OP_BEGIN, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_TICK, 32'd30, LINK_CONNECTED, BRK_OTHER, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_TICK, 32'd130, LINK_CONNECTED, BRK_OTHER, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_TICK, 32'd230, LINK_CONNECTED, BRK_DISCONNECTED, 1'b1, 1'b1,
                            ST_PROV));
        send_item(make_item(OP_TICK, 32'd330, LINK_CONNECTED, BRK_CONNECTED, 1'b1, 1'b1, ST_PROV));
        send_item(make_item(OP_TICK, 32'd430, LINK_CONNECTED, BRK_CONNECTED, 1'b0, 1'b1, ST_PROV));
        configure(2'd3, 4'd0);
        send_item(make_item(OP_FORCE, 32'd0, LINK_OTHER, BRK_DISCONNECTED, 1'b0, 1'b0,
                            ST_CONN_LINK));
        send_item(make_item(OP_TICK, 32'd530, LINK_CONNECTED, BRK_CONNECTED, 1'b1, 1'b1,
                            ST_PROV));
    endtask

    task automatic test_random();
        logic [3:0] limit_extremes [3];
        logic [1:0] mode;
        logic [3:0] limit;
        int         chunk;
        limit_extremes = '{4'd0, 4'd15, 4'd14};
        chunk = 0;
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 9 : (phase == 1) ? 61 : 0;
            sink_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 9 : 0;
            for (int k = 0; k < ((phase == 2) ? 5 : 6); k++) begin
                mode  = (chunk < 4) ? 2'(chunk)
                      : ($urandom_range(99) < 50) ? MODE_BROKER : 2'($urandom_range(3));
                limit = (chunk < 3) ? limit_extremes[chunk] : 4'($urandom_range(15));
                configure(mode, limit);
                repeat (100) send_item(random_item());
                chunk++;
            end
        end
    endtask

    task automatic check_field(string name, int expd, int actual);
        if (expd != actual) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expd, actual);
            errors++;
        end
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge aclk) begin : check_reports
        sup_report_t want;
        sup_report_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[6:0];
            if (expected_reports.size() == 0) begin
                $error("result transfer with nothing expected: m_tdata=%h", m_tdata);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                check_field("state_code", want.state_code, got.state_code);
                check_field("state_changed", want.state_changed, got.state_changed);
                check_field("led_level", want.led_level, got.led_level);
                check_field("broker_reset_cmd", want.rst_cmd, got.rst_cmd);
                check_field("broker_connect_cmd", want.con_cmd, got.con_cmd);
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_fail_count_limits();
        test_broker_session();
        test_random();
        drain_reports();
        repeat (4 * LATENCY) @(posedge aclk);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("link_supervisor_with_led_patterns test passed");
        end else begin
            $display("link_supervisor_with_led_patterns test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("link_supervisor_with_led_patterns test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lsled_pkg.sv
hw/rtl/lsled_step.sv
hw/rtl/link_supervisor_with_led_patterns.sv
sim/tb.sv
